// ===== sv/rau_pkg.sv =====
package rau_pkg;

  localparam int OperandWidth = 32;
  localparam int FieldW       = 32;
  localparam int MagW         = OperandWidth;
  localparam int ProdW        = 2 * MagW;
  localparam int WideW        = 64;
  localparam int DenW         = 63;
  localparam int OpW          = 2;
  localparam int StatusW      = 2;
  localparam int InTdataW     = 136;
  localparam int OutTdataW    = 136;
  localparam int CntW         = $clog2(WideW);
  localparam int ShW          = CntW + 1;

  typedef enum logic [OpW-1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    MUL_NONE = 2'd0,
    MUL_A    = 2'd1,
    MUL_B    = 2'd2,
    MUL_D    = 2'd3
  } mul_e;

  typedef struct packed {
    logic neg;
    logic [MagW-1:0] mag;
  } smag_t;

  typedef struct packed {
    logic load;
    mul_e mul;
    logic sum;
    logic check;
    logic gcd_step;
    logic div_start_num;
    logic div_start_den;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic den_zero;
    logic gcd_done;
    logic div_last;
  } sts_t;

  function automatic smag_t to_smag(logic [FieldW-1:0] x);
    logic [MagW-1:0] v;
    smag_t r;
    v = x[MagW-1:0];
    r.neg = v[MagW-1];
    r.mag = r.neg ? (~v + 1'b1) : v;
    return r;
  endfunction

endpackage

// ===== sv/rational_arithmetic_unit.sv =====
// channel  dir  tdata fields (low bit up)
// s_axis   in   operation[1:0], left_numerator, left_denominator, right_numerator,
//               right_denominator (32 each), zero pad to 136
// m_axis   out  result_numerator[63:0], result_denominator[126:64],
//               status[128:127], zero pad to 136
// One item at a time: multiply states MULA, MULB and MULD, sum, check, a binary
// gcd, then two restoring divides; the gcd loop and the divides are iterative.
// Both divides run on one shared bit-serial divider.
// A zero denominator skips gcd and divide.
// Reset clears the controller and the output valid; data registers hold.
// A new item is taken while a result waits; finishing stalls until it is taken.
module rational_arithmetic_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [rau_pkg::InTdataW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [rau_pkg::OutTdataW-1:0] m_axis_tdata
);

  rau_pkg::cmd_t cmd;
  rau_pkg::sts_t sts;

  rau_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rau_datapath u_datapath (
    .clk_i      (clk_i),
    .in_data_i  (s_axis_tdata),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (m_axis_tdata)
  );

endmodule

// ===== sv/rau_datapath.sv =====
module rau_datapath (
  input  logic                          clk_i,
  input  logic [rau_pkg::InTdataW-1:0]  in_data_i,
  input  rau_pkg::cmd_t                 cmd_i,
  output rau_pkg::sts_t                 sts_o,
  output logic [rau_pkg::OutTdataW-1:0] out_data_o
);

  localparam int W = rau_pkg::WideW;

  logic [rau_pkg::OpW-1:0] op_q;
  rau_pkg::smag_t ln_q, ld_q, rn_q, rd_q;
  rau_pkg::smag_t mx, my;
  logic [rau_pkg::ProdW-1:0] prod;
  logic pneg;

  logic [W-1:0] a_mag_q, b_mag_q, d_mag_q, num_mag_q;
  logic a_neg_q, b_neg_q, d_neg_q, num_neg_q, zden_q;
  logic [W-1:0] sum_mag;
  logic sum_neg;

  logic [W-1:0] u_q, v_q, g_q;
  logic [rau_pkg::ShW-1:0] k_q;
  logic [W-1:0] u_d, v_d;
  logic [rau_pkg::ShW-1:0] k_d;

  logic [W:0] rem_q, shifted, rem_sub;
  logic [W-1:0] dvd_q, qn_q;
  logic [rau_pkg::CntW-1:0] cnt_q;
  logic ge;

  logic res_neg, res_ovf;
  logic [W-1:0] res_num_q;
  logic [rau_pkg::DenW-1:0] res_den_q;
  logic [rau_pkg::StatusW-1:0] res_st_q;

  always_comb begin
    mx = ln_q;
    my = rd_q;
    case (cmd_i.mul)
      rau_pkg::MUL_A: begin
        mx = ln_q;
        my = (op_q == rau_pkg::OP_MUL) ? rn_q : rd_q;
      end
      rau_pkg::MUL_B: begin
        mx = rn_q;
        my = ld_q;
      end
      rau_pkg::MUL_D: begin
        mx = ld_q;
        my = (op_q == rau_pkg::OP_DIV) ? rn_q : rd_q;
      end
      default: begin
        mx = ln_q;
        my = rd_q;
      end
    endcase
    prod = rau_pkg::ProdW'(mx.mag) * rau_pkg::ProdW'(my.mag);
    pneg = (mx.mag != '0) && (my.mag != '0) && (mx.neg != my.neg);
  end

  always_comb begin
    if (a_neg_q == b_neg_q) begin
      sum_mag = a_mag_q + b_mag_q;
      sum_neg = a_neg_q;
    end else if (a_mag_q >= b_mag_q) begin
      sum_mag = a_mag_q - b_mag_q;
      sum_neg = a_neg_q;
    end else begin
      sum_mag = b_mag_q - a_mag_q;
      sum_neg = b_neg_q;
    end
    if (sum_mag == '0) sum_neg = 1'b0;
  end

  // binary gcd: one shift or subtract per cycle
  always_comb begin
    u_d = u_q;
    v_d = v_q;
    k_d = k_q;
    if (!u_q[0] && !v_q[0]) begin
      u_d = u_q >> 1;
      v_d = v_q >> 1;
      k_d = k_q + 1'b1;
    end else if (!u_q[0]) begin
      u_d = u_q >> 1;
    end else if (!v_q[0]) begin
      v_d = v_q >> 1;
    end else if (u_q >= v_q) begin
      u_d = (u_q - v_q) >> 1;
    end else begin
      v_d = (v_q - u_q) >> 1;
    end
  end

  assign shifted = {rem_q[W-1:0], dvd_q[W-1]};
  assign rem_sub = shifted - {1'b0, g_q};
  assign ge      = shifted >= {1'b0, g_q};

  assign res_neg = (qn_q != '0) && (num_neg_q != d_neg_q);
  assign res_ovf = res_neg ? (qn_q > {1'b1, {(W-1){1'b0}}}) : qn_q[W-1];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= in_data_i[rau_pkg::OpW-1:0];
      ln_q <= rau_pkg::to_smag(in_data_i[rau_pkg::OpW +: rau_pkg::FieldW]);
      ld_q <= rau_pkg::to_smag(in_data_i[rau_pkg::OpW+rau_pkg::FieldW +: rau_pkg::FieldW]);
      rn_q <= rau_pkg::to_smag(in_data_i[rau_pkg::OpW+2*rau_pkg::FieldW +: rau_pkg::FieldW]);
      rd_q <= rau_pkg::to_smag(in_data_i[rau_pkg::OpW+3*rau_pkg::FieldW +: rau_pkg::FieldW]);
    end
    case (cmd_i.mul)
      rau_pkg::MUL_A: begin
        a_mag_q <= W'(prod);
        a_neg_q <= pneg;
      end
      rau_pkg::MUL_B: begin
        if (op_q == rau_pkg::OP_ADD || op_q == rau_pkg::OP_SUB) begin
          b_mag_q <= W'(prod);
          b_neg_q <= (op_q == rau_pkg::OP_SUB) ? (!pneg && (prod != '0)) : pneg;
        end else begin
          b_mag_q <= '0;
          b_neg_q <= 1'b0;
        end
      end
      rau_pkg::MUL_D: begin
        d_mag_q <= W'(prod);
        d_neg_q <= pneg;
      end
      default: ;
    endcase
    if (cmd_i.sum) begin
      num_mag_q <= sum_mag;
      num_neg_q <= sum_neg;
    end
    if (cmd_i.check) begin
      zden_q <= (d_mag_q == '0);
      u_q    <= num_mag_q;
      v_q    <= d_mag_q;
      k_q    <= '0;
    end
    if (cmd_i.gcd_step) begin
      u_q <= u_d;
      v_q <= v_d;
      k_q <= k_d;
    end
    if (cmd_i.div_start_num) begin
      g_q   <= v_q << k_q;
      rem_q <= '0;
      dvd_q <= num_mag_q;
      cnt_q <= '0;
    end
    if (cmd_i.div_start_den) begin
      qn_q  <= dvd_q;
      rem_q <= '0;
      dvd_q <= d_mag_q;
      cnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? rem_sub : shifted;
      dvd_q <= {dvd_q[W-2:0], ge};
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.finish) begin
      if (zden_q) begin
        res_num_q <= '0;
        res_den_q <= '0;
        res_st_q  <= rau_pkg::ST_ZERO_DEN;
      end else if (res_ovf) begin
        res_num_q <= '0;
        res_den_q <= '0;
        res_st_q  <= rau_pkg::ST_OVERFLOW;
      end else begin
        res_num_q <= res_neg ? (~qn_q + 1'b1) : qn_q;
        res_den_q <= dvd_q[rau_pkg::DenW-1:0];
        res_st_q  <= rau_pkg::ST_OK;
      end
    end
  end

  assign sts_o.den_zero = (d_mag_q == '0);
  assign sts_o.gcd_done = (u_q == '0);
  assign sts_o.div_last = (cnt_q == rau_pkg::CntW'(W - 1));

  assign out_data_o = rau_pkg::OutTdataW'({res_st_q, res_den_q, res_num_q});

endmodule

// ===== sv/rau_ctrl.sv =====
module rau_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  rau_pkg::sts_t sts_i,
  output rau_pkg::cmd_t cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_MULA  = 11'b00000000010,
    S_MULB  = 11'b00000000100,
    S_MULD  = 11'b00000001000,
    S_SUM   = 11'b00000010000,
    S_CHECK = 11'b00000100000,
    S_GCD   = 11'b00001000000,
    S_DIVN  = 11'b00010000000,
    S_LOADD = 11'b00100000000,
    S_DIVD  = 11'b01000000000,
    S_FIN   = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic can_load;

  assign can_load = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.mul = rau_pkg::MUL_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_MULA;
        end
      end
      S_MULA: begin
        cmd_o.mul = rau_pkg::MUL_A;
        state_d = S_MULB;
      end
      S_MULB: begin
        cmd_o.mul = rau_pkg::MUL_B;
        state_d = S_MULD;
      end
      S_MULD: begin
        cmd_o.mul = rau_pkg::MUL_D;
        state_d = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d = sts_i.den_zero ? S_FIN : S_GCD;
      end
      S_GCD: begin
        if (sts_i.gcd_done) begin
          cmd_o.div_start_num = 1'b1;
          state_d = S_DIVN;
        end else begin
          cmd_o.gcd_step = 1'b1;
        end
      end
      S_DIVN: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_LOADD;
      end
      S_LOADD: begin
        cmd_o.div_start_den = 1'b1;
        state_d = S_DIVD;
      end
      S_DIVD: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_FIN;
      end
      S_FIN: begin
        if (can_load) begin
          cmd_o.finish = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.finish) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_MULA))
    else $error("accepted item did not start multiply");

  a_finish_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && can_load) |=> (out_valid_q && state_q == S_IDLE))
    else $error("finished result not presented");

  a_gcd_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GCD && !sts_i.gcd_done) |=> (state_q == S_GCD))
    else $error("gcd left early");

endmodule
